FILE: design/cfd_pkg.sv
// ============================================================================
// cfd_pkg
// shared types, codes and the crc16 byte update for the frame deframer
// ============================================================================
package cfd_pkg;

    // queue between classifier and executor, power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [7:0]  HDR_FIRST_RST  = 8'hFF;
    localparam logic [7:0]  HDR_SECOND_RST = 8'hA5;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  MIN_FRAME_LEN  = 8'd7;
    // header, length, device, command and both crc bytes, plus the byte just taken
    localparam logic [8:0]  PAY_TAIL       = 9'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_FIRST  = 2'd0,
        CFG_HDR_SECOND = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_PAYLOAD   = 2'd0,
        EV_FRAME_END = 2'd1,
        EV_LEN_ERR   = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DEV   = 3'd3,
        PH_CMD   = 3'd4,
        PH_PAY   = 3'd5,
        PH_CRC1  = 3'd6,
        PH_CRC2  = 3'd7
    } t_phase;

    // what the executor has to do with a queued byte
    typedef enum logic [2:0] {
        K_HDR1 = 3'd0,
        K_HDR2 = 3'd1,
        K_LEN  = 3'd2,
        K_DEV  = 3'd3,
        K_CMD  = 3'd4,
        K_PAY  = 3'd5,
        K_CRC1 = 3'd6,
        K_CRC2 = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] idx;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qpush;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: design/cfd_front.sv
// ============================================================================
// cfd_front
// header hunt and position tracking, tags each frame byte for the executor
// ============================================================================
module cfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_hdr_first,
    input  logic [7:0]       i_hdr_second,
    output cfd_pkg::t_qpush  o_push
);
    import cfd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pay_idx, n_pay_idx;
    t_qpush     push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_len     <= '0;
            r_pay_idx <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_pay_idx <= n_pay_idx;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_pay_idx      = r_pay_idx;
        push.valid     = 1'b0;
        push.ent.kind  = K_HDR1;
        push.ent.data  = i_byte;
        push.ent.idx   = r_pay_idx;
        if (i_take) begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (i_byte == i_hdr_first) begin
                        n_phase    = PH_HUNT2;
                        push.valid = 1'b1;
                    end
                end
                PH_HUNT2: begin
                    if (i_byte == i_hdr_second) begin
                        n_phase       = PH_LEN;
                        push.valid    = 1'b1;
                        push.ent.kind = K_HDR2;
                    end else if (i_byte == i_hdr_first) begin
                        // repeated first byte restarts the header crc
                        push.valid = 1'b1;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_LEN: begin
                    n_len         = i_byte;
                    push.valid    = 1'b1;
                    push.ent.kind = K_LEN;
                    n_phase       = (i_byte < MIN_FRAME_LEN) ? PH_HUNT1 : PH_DEV;
                end
                PH_DEV: begin
                    push.valid    = 1'b1;
                    push.ent.kind = K_DEV;
                    n_phase       = PH_CMD;
                end
                PH_CMD: begin
                    push.valid    = 1'b1;
                    push.ent.kind = K_CMD;
                    n_pay_idx     = '0;
                    n_phase       = (r_len == MIN_FRAME_LEN) ? PH_CRC1 : PH_PAY;
                end
                PH_PAY: begin
                    push.valid    = 1'b1;
                    push.ent.kind = K_PAY;
                    n_pay_idx     = r_pay_idx + 8'd1;
                    if ({1'b0, r_pay_idx} + PAY_TAIL >= {1'b0, r_len}) begin
                        n_phase = PH_CRC1;
                    end
                end
                PH_CRC1: begin
                    push.valid    = 1'b1;
                    push.ent.kind = K_CRC1;
                    n_phase       = PH_CRC2;
                end
                PH_CRC2: begin
                    push.valid    = 1'b1;
                    push.ent.kind = K_CRC2;
                    n_phase       = PH_HUNT1;
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    assign o_push = push;

endmodule

FILE: design/cfd_queue.sv
// ============================================================================
// cfd_queue
// small register queue of tagged bytes between classifier and executor
// ============================================================================
module cfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_qpush  i_push,
    input  logic             i_pop,
    output cfd_pkg::t_qent   o_head,
    output cfd_pkg::t_qstat  o_stat
);
    import cfd_pkg::*;

    t_qent              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               full;
    logic               empty;

    assign full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.ent;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0))
        else $error("queue not empty after reset");

endmodule

FILE: design/cfd_back.sv
// ============================================================================
// cfd_back
// executes tagged bytes: running crc, frame fields and the result register
// ============================================================================
module cfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_qent   i_head,
    input  cfd_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_event_res,
    output logic             o_crc_ok,
    output logic [7:0]       o_node_id,
    output logic [7:0]       o_command,
    output logic [7:0]       o_payload_byte,
    output logic [7:0]       o_byte_index,
    output logic [7:0]       o_frame_length
);
    import cfd_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_crc_first, n_crc_first;

    logic        r_out_valid, n_out_valid;
    t_event      r_ev, n_ev;
    logic        r_ok, n_ok;
    logic [7:0]  r_o_dev, n_o_dev;
    logic [7:0]  r_o_cmd, n_o_cmd;
    logic [7:0]  r_o_pay, n_o_pay;
    logic [7:0]  r_o_idx, n_o_idx;
    logic [7:0]  r_o_len, n_o_len;

    logic        pop;
    logic        emit;
    logic [15:0] crc_upd;

    // pop whenever the result slot is free or is being emptied
    assign pop     = !i_qstat.empty && (!r_out_valid || i_out_ready);
    assign crc_upd = crc_byte(r_crc, i_head.data);

    always_comb begin
        n_crc       = r_crc;
        n_len       = r_len;
        n_dev       = r_dev;
        n_cmd       = r_cmd;
        n_crc_first = r_crc_first;
        emit        = 1'b0;
        n_ev        = EV_PAYLOAD;
        n_ok        = 1'b0;
        n_o_dev     = r_dev;
        n_o_cmd     = r_cmd;
        n_o_pay     = 8'h00;
        n_o_idx     = 8'h00;
        n_o_len     = r_len;
        if (pop) begin
            unique case (i_head.kind)
                K_HDR1: n_crc = crc_byte(CRC_INIT, i_head.data);
                K_HDR2: n_crc = crc_upd;
                K_LEN: begin
                    n_crc = crc_upd;
                    n_len = i_head.data;
                    if (i_head.data < MIN_FRAME_LEN) begin
                        emit    = 1'b1;
                        n_ev    = EV_LEN_ERR;
                        n_o_dev = 8'h00;
                        n_o_cmd = 8'h00;
                        n_o_len = i_head.data;
                    end
                end
                K_DEV: begin
                    n_crc = crc_upd;
                    n_dev = i_head.data;
                end
                K_CMD: begin
                    n_crc = crc_upd;
                    n_cmd = i_head.data;
                end
                K_PAY: begin
                    n_crc   = crc_upd;
                    emit    = 1'b1;
                    n_ev    = EV_PAYLOAD;
                    n_o_pay = i_head.data;
                    n_o_idx = i_head.idx;
                end
                K_CRC1: n_crc_first = i_head.data;
                K_CRC2: begin
                    emit = 1'b1;
                    n_ev = EV_FRAME_END;
                    n_ok = (r_crc_first == r_crc[15:8]) && (i_head.data == r_crc[7:0]);
                end
                default: n_crc = r_crc;
            endcase
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_dev       <= n_dev;
        r_cmd       <= n_cmd;
        r_crc_first <= n_crc_first;
        if (emit) begin
            r_ev    <= n_ev;
            r_ok    <= n_ok;
            r_o_dev <= n_o_dev;
            r_o_cmd <= n_o_cmd;
            r_o_pay <= n_o_pay;
            r_o_idx <= n_o_idx;
            r_o_len <= n_o_len;
        end
    end

    assign o_pop          = pop;
    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_ev;
    assign o_crc_ok       = r_ok;
    assign o_node_id      = r_o_dev;
    assign o_command      = r_o_cmd;
    assign o_payload_byte = r_o_pay;
    assign o_byte_index   = r_o_idx;
    assign o_frame_length = r_o_len;

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !pop)
        else $error("result slot overwritten while held");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted result not presented");

    a_crc_ok_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> (r_ev == EV_FRAME_END))
        else $error("crc flag set on non frame end result");

endmodule

FILE: design/crc16_frame_deframer_unit.sv
// ============================================================================
// crc16_frame_deframer_unit
// streaming deframer for crc16-modbus protected packets with header hunt
// ============================================================================
// a taken byte is written into the queue, then executed into the result register
// throughput: one byte per cycle while the queue has room, set by the one-byte unrolled crc update in the executor
// input stalls only when the two-entry queue is full, i.e. when results back up
// reset (synchronous, active low): hunting for the first header byte, queue empty,
// no result pending, header bytes back to 0xff and 0xa5
module crc16_frame_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_event_res,
    output logic                          o_crc_ok,
    output logic [7:0]                    o_node_id,
    output logic [7:0]                    o_command,
    output logic [7:0]                    o_payload_byte,
    output logic [7:0]                    o_byte_index,
    output logic [7:0]                    o_frame_length
);
    import cfd_pkg::*;

    // header pattern registers
    logic [7:0] r_hdr_first;
    logic [7:0] r_hdr_second;

    logic       take;
    t_qpush     q_push;
    t_qent      q_head;
    t_qstat     q_stat;
    logic       q_pop;

    // config port is always able to take a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HDR_FIRST_RST;
            r_hdr_second <= HDR_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_hdr_second <= i_cfg_data;
                default: begin
                    // indexes beyond the register list are ignored
                end
            endcase
        end
    end

    // front takes a byte whenever the queue has room, even while a result waits
    assign o_in_ready = !q_stat.full;
    assign take       = i_in_valid && o_in_ready;

    // classifier: hunt, frame position, payload index
    cfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte       (i_data_byte),
        .i_hdr_first  (r_hdr_first),
        .i_hdr_second (r_hdr_second),
        .o_push       (q_push)
    );

    // decoupling queue, holds up to two tagged bytes while the result side stalls; input stops once it is full
    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // executor: crc, held frame fields, output register
    cfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_qstat        (q_stat),
        .o_pop          (q_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_event_res    (o_event_res),
        .o_crc_ok       (o_crc_ok),
        .o_node_id      (o_node_id),
        .o_command      (o_command),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length)
    );

    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> take)
        else $error("queue entry without an accepted item");

    a_frame_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_FRAME_END)) |->
            ((o_payload_byte == 8'h00) && (o_byte_index == 8'h00)))
        else $error("frame end result carries payload fields");

    a_len_err_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_LEN_ERR)) |-> (o_frame_length < MIN_FRAME_LEN))
        else $error("length error reported for a legal length");

endmodule
